/* src/sem_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int PIX_W   = 8;
   localparam int RGB_W   = 3 * PIX_W;
   localparam int FW_W    = 12;
   localparam int FH_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int G_W     = 11;   // signed Sobel sum, |G| <= 1020
   localparam int SQ_W    = 21;   // Gx^2 + Gy^2 <= 2080800
   localparam int ROOT_W  = 22;
   localparam int MAG_W   = 11;
   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;
   localparam logic [FW_W-1:0] FW_RESET = 12'd640;
   localparam logic [FH_W-1:0] FH_RESET = 13'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_SQUARE,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic sum;
      logic square;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic root_last;
   } status_type;

endpackage
`default_nettype wire

/* src/sem_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

/* src/sem_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accept, window load, Sobel sums, squares, root steps, emit.
// ----------------------------------------------------------------------------
module sem_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire sem_pkg::status_type status,
   output sem_pkg::cmd_type         cmd
);
   import sem_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (status.has_result) begin
               cmd.sum  = 1'b1;
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.out_load;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* src/sem_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sem_datapath
// Frame registers, position counters, line store, window, Sobel sums and
// three bit-pair root lanes with rounding and clamp.
// ----------------------------------------------------------------------------
module sem_datapath #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sem_pkg::cmd_type                     cmd,
   output sem_pkg::status_type                       status,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  wire logic [sem_pkg::PIX_W-1:0]            req_pixel_red,
   input  wire logic [sem_pkg::PIX_W-1:0]            req_pixel_green,
   input  wire logic [sem_pkg::PIX_W-1:0]            req_pixel_blue,
   output logic      [sem_pkg::PIX_W-1:0]            rsp_edge_red,
   output logic      [sem_pkg::PIX_W-1:0]            rsp_edge_green,
   output logic      [sem_pkg::PIX_W-1:0]            rsp_edge_blue,
   output logic                                      rsp_frame_end
);
   import sem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = WW + 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 2);
   localparam int YW = RW + 1;

   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [WW-1:0]    eff_w;
   logic [HW-1:0]    eff_h;
   logic [CW-1:0]    col_eff;
   logic [RGB_W-1:0] pix_ff;
   logic [RGB_W-1:0] win_ff [9];
   logic [2*RGB_W-1:0] ram_rdata;

   // window masks and end flag
   logic ok_c0_ff, ok_c2_ff, ok_r0_ff, ok_r2_ff, end_ff, has_ff;
   logic ok_c0_in, ok_c2_in, ok_r0_in, ok_r2_in, end_in, has_in;

   logic signed [G_W-1:0] gx_ff [3];
   logic signed [G_W-1:0] gy_ff [3];
   logic signed [G_W-1:0] gx_in [3];
   logic signed [G_W-1:0] gy_in [3];
   logic [SQ_W-1:0]   rem_ff [3];
   logic [SQ_W-1:0]   rem_in [3];
   logic [ROOT_W-1:0] root_ff [3];
   logic [ROOT_W-1:0] root_in [3];
   logic [SQ_W-1:0]   bit_ff;
   logic [PIX_W-1:0]  edge_ff [3];
   logic [PIX_W-1:0]  edge_in [3];
   logic              frame_end_ff;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(frame_height_ff);
      end
      col_eff = (XW'(col_ff) >= XW'(eff_w)) ? '0 : col_ff;
   end

   sem_ram #(
      .WIDTH(2 * RGB_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock       (clock),
      .write_enable(cmd.load),
      .write_addr  (col_eff),
      .write_data  ({ram_rdata[RGB_W-1:0], pix_ff}),
      .read_enable (cmd.accept),
      .read_addr   (col_eff),
      .read_data   (ram_rdata)
   );

   // position, masks, next position
   always_comb begin
      logic [XW-1:0] cx, wx, xx, cn;
      logic [YW-1:0] rx, hx, yy;
      cx = XW'(col_eff);
      wx = XW'(eff_w);
      rx = YW'(row_ff);
      hx = YW'(eff_h);
      if (col_eff == '0) begin
         has_in = (rx >= YW'(2)) && (rx <= hx + YW'(1));
         yy     = rx - YW'(2);
         xx     = wx - XW'(1);
      end else begin
         has_in = (rx >= YW'(1)) && (rx <= hx);
         yy     = rx - YW'(1);
         xx     = cx - XW'(1);
      end
      ok_c0_in = xx >= XW'(1);
      ok_c2_in = xx + XW'(1) < wx;
      ok_r0_in = yy >= YW'(1);
      ok_r2_in = yy + YW'(1) < hx;
      end_in   = (yy == hx - YW'(1)) && (xx == wx - XW'(1));
      cn       = cx + XW'(1);
      if (rx >= hx + YW'(1)) begin
         col_in = '0;
         row_in = '0;
      end else if (cn >= wx) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = CW'(cn);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         has_ff          <= 1'b0;
      end else if (csr_write_enable &&
                   (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_write_data[FW_W-1:0];
         end else begin
            frame_height_ff <= csr_write_data[FH_W-1:0];
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
         has_ff <= has_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= {req_pixel_blue, req_pixel_green, req_pixel_red};
      end
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= ram_rdata[2*RGB_W-1:RGB_W];
         win_ff[5] <= ram_rdata[RGB_W-1:0];
         win_ff[8] <= pix_ff;
         ok_c0_ff  <= ok_c0_in;
         ok_c2_ff  <= ok_c2_in;
         ok_r0_ff  <= ok_r0_in;
         ok_r2_ff  <= ok_r2_in;
         end_ff    <= end_in;
      end
      if (cmd.sum) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (cmd.square || cmd.root_step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.square) begin
         bit_ff <= SQ_W'(1) << (SQ_W - 1);
      end else if (cmd.root_step) begin
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.out_load) begin
         edge_ff      <= edge_in;
         frame_end_ff <= end_ff;
      end
   end

   // Sobel sums, one lane per colour
   always_comb begin
      logic signed [G_W-1:0] p [9];
      logic ok [9];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ok[i*3+j] = ((i != 0) || ok_r0_ff) && ((i != 2) || ok_r2_ff) &&
                        ((j != 0) || ok_c0_ff) && ((j != 2) || ok_c2_ff);
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 9; k++) begin
            p[k] = ok[k] ? $signed(G_W'(win_ff[k][ch*PIX_W +: PIX_W])) : '0;
         end
         gx_in[ch] = p[2] - p[0] + ((p[5] - p[3]) <<< 1) + p[8] - p[6];
         gy_in[ch] = p[6] - p[0] + ((p[7] - p[1]) <<< 1) + p[8] - p[2];
      end
   end

   // squares on the square command, then one bit pair per root step
   always_comb begin
      logic signed [2*G_W-1:0] sx, sy;
      logic [ROOT_W-1:0] t;
      logic [MAG_W-1:0]  n;
      for (int ch = 0; ch < 3; ch++) begin
         sx = gx_ff[ch] * gx_ff[ch];
         sy = gy_ff[ch] * gy_ff[ch];
         t  = root_ff[ch] + ROOT_W'(bit_ff);
         if (cmd.square) begin
            rem_in[ch]  = SQ_W'(sx) + SQ_W'(sy);
            root_in[ch] = '0;
         end else if (ROOT_W'(rem_ff[ch]) >= t) begin
            rem_in[ch]  = rem_ff[ch] - SQ_W'(t);
            root_in[ch] = (root_ff[ch] >> 1) + ROOT_W'(bit_ff);
         end else begin
            rem_in[ch]  = rem_ff[ch];
            root_in[ch] = root_ff[ch] >> 1;
         end
         n = MAG_W'(root_ff[ch]);
         if (ROOT_W'(rem_ff[ch]) > root_ff[ch]) begin
            n = n + MAG_W'(1);
         end
         edge_in[ch] = (n > MAG_W'(MAG_MAX)) ? MAG_MAX : PIX_W'(n);
      end
   end

   assign status.has_result = has_ff;
   assign status.root_last  = bit_ff[0];

   assign rsp_edge_red   = edge_ff[0];
   assign rsp_edge_green = edge_ff[1];
   assign rsp_edge_blue  = edge_ff[2];
   assign rsp_frame_end  = frame_end_ff;

endmodule
`default_nettype wire

/* src/sobel_edge_magnitude_rgb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude per colour channel over a line store.
// ----------------------------------------------------------------------------
// Flow: one word at a time; req_stall holds through load and sum check, and for
//   a result also through squares, eleven-step bit-pair square root and emit.
// Output: registered in emit once rsp_stall allows, for the word completing its
//   window, which is frame_width+1 words after the pixel itself.
// Reset: synchronous; 640 x 480 frame, counters at frame start, no output.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sem_pkg::PIX_W-1:0]       req_pixel_red,
   input  wire logic [sem_pkg::PIX_W-1:0]       req_pixel_green,
   input  wire logic [sem_pkg::PIX_W-1:0]       req_pixel_blue,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [sem_pkg::PIX_W-1:0]       rsp_edge_red,
   output logic      [sem_pkg::PIX_W-1:0]       rsp_edge_green,
   output logic      [sem_pkg::PIX_W-1:0]       rsp_edge_blue,
   output logic                                 rsp_frame_end
);
   import sem_pkg::*;

   cmd_type    cmd;
   status_type status;

   sem_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .rsp_edge_red    (rsp_edge_red),
      .rsp_edge_green  (rsp_edge_green),
      .rsp_edge_blue   (rsp_edge_blue),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
`default_nettype wire
